[design/quaternion_to_pointer_velocity_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to pointer velocity block
// Short wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_POINTER_VELOCITY_TOP_MACROS_SVH
`define QUATERNION_TO_POINTER_VELOCITY_TOP_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define QPV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define QPV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/qpv_pkg.sv]
// ----------------------------------------------------------------------------
// qpv_pkg
// Shared types, constants and tables of the pointer velocity block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qpv_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CORDIC_STEPS    = 22;
    localparam int CW              = 38;
    localparam int AW              = 26;
    localparam int MAXW            = 15;

    localparam logic [MAXW-1:0] MAX_RESET = 15'd8192;
    localparam logic signed [AW-1:0] QUARTER24 = 26'sd4194304;
    localparam logic signed [15:0] ANGLE_QUARTER = 16'sd16384;
    localparam logic signed [15:0] ANGLE_HALF_NEG = -16'sd32768;
    localparam logic [6:0] VEL_SCALE = 7'd100;

    typedef logic signed [AW-1:0] t_acc;

    // Register indexes of the configuration port.
    typedef enum logic {
        REG_MAX_PITCH = 1'b0,
        REG_MAX_YAW   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [MAXW-1:0] max_pitch;
        logic [MAXW-1:0] max_yaw;
    } t_cfg;

    // One classified word handed from the front to the back.
    typedef struct packed {
        logic signed [29:0] s;
        logic signed [34:0] num;
        logic signed [34:0] den;
        logic               elbow;
        logic               mouse;
    } t_work;

    // Arctangent of 2^-i in units of 2^24 per turn.
    function automatic t_acc atan_entry(input logic [4:0] i);
        t_acc v;
        case (i)
            5'd0:  v = 26'sd2097152;
            5'd1:  v = 26'sd1238021;
            5'd2:  v = 26'sd654136;
            5'd3:  v = 26'sd332050;
            5'd4:  v = 26'sd166669;
            5'd5:  v = 26'sd83416;
            5'd6:  v = 26'sd41718;
            5'd7:  v = 26'sd20860;
            5'd8:  v = 26'sd10430;
            5'd9:  v = 26'sd5215;
            5'd10: v = 26'sd2608;
            5'd11: v = 26'sd1304;
            5'd12: v = 26'sd652;
            5'd13: v = 26'sd326;
            5'd14: v = 26'sd163;
            5'd15: v = 26'sd81;
            5'd16: v = 26'sd41;
            5'd17: v = 26'sd20;
            5'd18: v = 26'sd10;
            5'd19: v = 26'sd5;
            5'd20: v = 26'sd3;
            5'd21: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/qpv_front.sv]
// ----------------------------------------------------------------------------
// qpv_front
// Accepts a quaternion word and forms the sine term and the yaw vector with
// one shared 16x16 multiplier, then pushes the result into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpv_front import qpv_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic               i_toward_elbow,
    input  wire logic               i_pointer_mode,
    output logic                    o_push,
    output t_work                   o_work,
    input  wire logic               i_full
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} t_fstate;

    t_fstate            r_state;
    logic [2:0]         r_cnt;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic               r_elbow, r_mouse;
    logic signed [31:0] r_prod;
    logic signed [32:0] r_t1, r_t2, r_t3;
    logic signed [15:0] w_ma, w_mb;
    logic signed [33:0] w_s2;

    // Operand pair for the product of this cycle.
    always_comb begin
        case (r_cnt)
            3'd0:    begin w_ma = r_qw; w_mb = r_qy; end
            3'd1:    begin w_ma = r_qz; w_mb = r_qx; end
            3'd2:    begin w_ma = r_qw; w_mb = r_qz; end
            3'd3:    begin w_ma = r_qx; w_mb = r_qy; end
            3'd4:    begin w_ma = r_qy; w_mb = r_qy; end
            3'd5:    begin w_ma = r_qz; w_mb = r_qz; end
            default: begin w_ma = '0;   w_mb = '0;   end
        endcase
    end

    // Sequencer: one product per cycle, summed in the cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_qx    <= i_quat_x;
                        r_qy    <= i_quat_y;
                        r_qz    <= i_quat_z;
                        r_qw    <= i_quat_w;
                        r_elbow <= i_toward_elbow;
                        r_mouse <= i_pointer_mode;
                        r_t1    <= '0;
                        r_t2    <= '0;
                        r_t3    <= '0;
                        r_cnt   <= '0;
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_prod <= w_ma * w_mb;
                    case (r_cnt) inside
                        3'd1:       r_t1 <= r_t1 + 33'(r_prod);
                        3'd2:       r_t1 <= r_t1 - 33'(r_prod);
                        3'd3, 3'd4: r_t2 <= r_t2 + 33'(r_prod);
                        3'd5, 3'd6: r_t3 <= r_t3 + 33'(r_prod);
                        default: ;
                    endcase
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd6) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Sine term clamped to one, yaw numerator and denominator.
    always_comb begin
        w_s2 = 34'(r_t1) <<< 1;
        if (w_s2 > 34'sd268435456) begin
            o_work.s = 30'sd268435456;
        end else if (w_s2 < -34'sd268435456) begin
            o_work.s = -30'sd268435456;
        end else begin
            o_work.s = w_s2[29:0];
        end
        o_work.num   = 35'(r_t2) <<< 1;
        o_work.den   = 35'sd268435456 - (35'(r_t3) <<< 1);
        o_work.elbow = r_elbow;
        o_work.mouse = r_mouse;
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;

endmodule

`default_nettype wire

[design/qpv_queue.sv]
// ----------------------------------------------------------------------------
// qpv_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpv_queue import qpv_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_work      i_work,
    input  wire logic  i_pop,
    output t_work      o_head,
    output logic       o_empty,
    output logic       o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_work           r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CNTW-1:0] r_count;

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNTW'(DEPTH));

endmodule

`default_nettype wire

[design/qpv_back.sv]
// ----------------------------------------------------------------------------
// qpv_back
// Works one word at a time: square root for the pitch cosine, two CORDIC
// arctangents on a shared unit, mode tracking, and a restoring divider that
// scales each angle delta into a velocity in mouse mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qpv_back import qpv_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  t_work                  i_head,
    output logic                   o_pop,
    input  t_cfg                   i_cfg,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_status,
    output logic signed [7:0]      o_velocity_x,
    output logic signed [7:0]      o_velocity_y
);

    typedef enum logic [3:0] {
        B_IDLE, B_SQ, B_SQRT, B_PINIT, B_PROT, B_YINIT, B_YROT,
        B_ANG, B_DMUL, B_DIV, B_DONE
    } t_bstate;

    localparam logic [56:0] ONE56 = 57'd1 << 56;

    t_bstate              r_state;
    t_work                r_w;
    logic [56:0]          r_rem, r_root, r_bit;
    logic signed [CW-1:0] r_cx, r_cy;
    t_acc                 r_acc;
    logic [4:0]           r_cnt;
    logic                 r_xzero;
    logic signed [15:0]   r_spec;
    logic signed [15:0]   r_pitch;
    logic signed [16:0]   r_dlt_p, r_dlt_y;
    logic                 r_axis;
    logic [21:0]          r_dvd, r_q;
    logic [MAXW-1:0]      r_dr;
    logic                 r_neg;
    logic                 r_was;
    logic signed [15:0]   r_base_p, r_base_y;
    logic                 r_status;
    logic signed [7:0]    r_vx, r_vy;
    logic                 r_ovalid, r_ostatus;
    logic signed [7:0]    r_ovx, r_ovy;

    logic signed [59:0]   w_sq;
    logic [56:0]          w_trial;
    logic signed [CW-1:0] w_ix, w_iy, w_px, w_py, w_xs, w_ys, w_nx, w_ny;
    t_acc                 w_pacc, w_nacc, w_rnd;
    logic signed [15:0]   w_ispec, w_a16, w_yaw, w_bp, w_by;
    logic                 w_cap;
    logic signed [16:0]   w_dsel;
    logic [16:0]          w_mag;
    logic [MAXW-1:0]      w_maxv, w_dvs;
    logic [MAXW:0]        w_rr;
    logic                 w_qbit;
    logic [21:0]          w_qfin;
    logic [6:0]           w_vmag;
    logic signed [7:0]    w_vel;
    logic                 w_load;

    // Wrapped ring difference; a half turn on either side gives zero.
    function automatic logic signed [16:0] ring_delta(
        input logic signed [15:0] cur,
        input logic signed [15:0] base
    );
        logic signed [17:0] d;
        d = 18'(cur) - 18'(base);
        if (d > 18'sd32768) begin
            d = d - 18'sd65536;
        end else if (d < -18'sd32768) begin
            d = d + 18'sd65536;
        end
        if (cur == ANGLE_HALF_NEG || base == ANGLE_HALF_NEG) begin
            d = '0;
        end
        return d[16:0];
    endfunction

    // Square of the sine term and one root digit.
    assign w_sq    = r_w.s * r_w.s;
    assign w_trial = r_root + r_bit;

    // CORDIC entry: pitch vector (s, c) or yaw vector (num, den), with the
    // left half plane turned by a quarter turn first.
    always_comb begin
        if (r_state == B_PINIT) begin
            w_iy = CW'(r_w.s);
            w_ix = CW'($signed({1'b0, r_root[28:0]}));
        end else begin
            w_iy = CW'(r_w.num);
            w_ix = CW'(r_w.den);
        end
        if (w_ix < 0) begin
            if (w_iy >= 0) begin
                w_px = w_iy;  w_py = -w_ix; w_pacc = QUARTER24;
            end else begin
                w_px = -w_iy; w_py = w_ix;  w_pacc = -QUARTER24;
            end
        end else begin
            w_px = w_ix; w_py = w_iy; w_pacc = '0;
        end
        if (w_iy == 0) begin
            w_ispec = '0;
        end else if (w_iy > 0) begin
            w_ispec = ANGLE_QUARTER;
        end else begin
            w_ispec = -ANGLE_QUARTER;
        end
    end

    // One CORDIC vectoring step.
    always_comb begin
        w_xs = r_cx >>> r_cnt;
        w_ys = r_cy >>> r_cnt;
        if (r_cy > 0) begin
            w_nx   = r_cx + w_ys;
            w_ny   = r_cy - w_xs;
            w_nacc = r_acc + atan_entry(r_cnt);
        end else begin
            w_nx   = r_cx - w_ys;
            w_ny   = r_cy + w_xs;
            w_nacc = r_acc - atan_entry(r_cnt);
        end
    end

    // Rounded 16-bit angle, yaw and base selection on entering mouse mode.
    always_comb begin
        w_rnd = r_acc + 26'sd128;
        w_a16 = r_xzero ? r_spec : w_rnd[23:8];
        w_yaw = -w_a16;
        w_cap = !r_was && r_w.mouse;
        w_bp  = w_cap ? r_pitch : r_base_p;
        w_by  = w_cap ? w_yaw : r_base_y;
    end

    // Divider operands and one restoring step.
    always_comb begin
        w_dsel = r_axis ? r_dlt_y : r_dlt_p;
        w_mag  = (w_dsel < 0) ? 17'(-w_dsel) : 17'(w_dsel);
        w_maxv = r_axis ? i_cfg.max_yaw : i_cfg.max_pitch;
        w_dvs  = (w_maxv == '0) ? MAXW'(1) : w_maxv;
        w_rr   = {r_dr, r_dvd[21]};
        w_qbit = (w_rr >= {1'b0, w_dvs});
        w_qfin = {r_q[20:0], w_qbit};
        w_vmag = (w_qfin > 22'd100) ? VEL_SCALE : w_qfin[6:0];
        w_vel  = r_neg ? -$signed({1'b0, w_vmag}) : $signed({1'b0, w_vmag});
    end

    // The result register takes a new word when it is free or being emptied.
    assign w_load = (r_state == B_DONE) && (!r_ovalid || i_ready);

    // Main sequencer with the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_was    <= 1'b0;
            r_base_p <= '0;
            r_base_y <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_w     <= i_head;
                        r_state <= B_SQ;
                    end
                end
                B_SQ: begin
                    r_rem   <= ONE56 - w_sq[56:0];
                    r_root  <= '0;
                    r_bit   <= ONE56;
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    if (r_rem >= w_trial) begin
                        r_rem  <= r_rem - w_trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= B_PINIT;
                    end
                end
                B_PINIT, B_YINIT: begin
                    if (r_state == B_YINIT) begin
                        r_pitch <= r_w.elbow ? w_a16 : -w_a16;
                    end
                    r_cx    <= w_px;
                    r_cy    <= w_py;
                    r_acc   <= w_pacc;
                    r_xzero <= (w_ix == 0);
                    r_spec  <= w_ispec;
                    r_cnt   <= '0;
                    r_state <= (r_state == B_PINIT) ? B_PROT : B_YROT;
                end
                B_PROT, B_YROT: begin
                    r_cx  <= w_nx;
                    r_cy  <= w_ny;
                    r_acc <= w_nacc;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= (r_state == B_PROT) ? B_YINIT : B_ANG;
                    end
                end
                B_ANG: begin
                    r_base_p <= w_bp;
                    r_base_y <= w_by;
                    r_was    <= r_w.mouse;
                    r_dlt_p  <= ring_delta(r_pitch, w_bp);
                    r_dlt_y  <= ring_delta(w_yaw, w_by);
                    r_axis   <= 1'b0;
                    r_vx     <= '0;
                    r_vy     <= '0;
                    if (r_w.mouse) begin
                        r_status <= 1'b0;
                        r_state  <= B_DMUL;
                    end else begin
                        r_status <= !r_was;
                        r_state  <= B_DONE;
                    end
                end
                B_DMUL: begin
                    r_dvd   <= 22'(w_mag * VEL_SCALE);
                    r_neg   <= (w_dsel < 0);
                    r_dr    <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_dr  <= w_qbit ? MAXW'(w_rr - {1'b0, w_dvs}) : w_rr[MAXW-1:0];
                    r_dvd <= r_dvd << 1;
                    r_q   <= w_qfin;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd21) begin
                        if (r_axis) begin
                            r_vx    <= w_vel;
                            r_state <= B_DONE;
                        end else begin
                            r_vy    <= w_vel;
                            r_axis  <= 1'b1;
                            r_state <= B_DMUL;
                        end
                    end
                end
                B_DONE: begin
                    if (w_load) begin
                        r_ostatus <= r_status;
                        r_ovx     <= r_vx;
                        r_ovy     <= r_vy;
                        r_state   <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_pop        = (r_state == B_IDLE) && !i_empty;
    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_velocity_x = r_ovx;
    assign o_velocity_y = r_ovy;

endmodule

`default_nettype wire

[design/quaternion_to_pointer_velocity_top.sv]
// ----------------------------------------------------------------------------
// Channel   Direction  tdata (low bit up)                     tuser
// s_axis    in         quat_x, quat_y, quat_z, quat_w        toward_elbow, pointer_mode
// m_axis    out        velocity_x, velocity_y                status
// cfg       in         write enable, index, 15-bit data      -
//
// The front takes a new word only after it has pushed the last into the queue.
// The back runs a 29-step square root and two 22-step CORDIC passes on one
// shared unit for each word, and in mouse mode two 22-step divisions as well.
// Reset is synchronous and active low; both maxima return to 8192.
// The queue between front and back and the result register let the input
// side keep accepting while a result waits on m_axis_tready.
// ----------------------------------------------------------------------------
// quaternion_to_pointer_velocity_top
// Orientation quaternion to pointer velocity, with mouse mode base capture.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_to_pointer_velocity_top_macros.svh"

module quaternion_to_pointer_velocity_top import qpv_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [63:0]      s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    input  wire logic [1:0]       s_axis_tuser,   // toward_elbow, pointer_mode
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // velocity_x, velocity_y
    output logic [0:0]            m_axis_tuser,   // status
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [MAXW-1:0]  i_cfg_wdata
);

    t_cfg              r_cfg;
    t_work             w_work, w_head;
    logic              w_push, w_pop, w_empty, w_full, w_in_valid;
    logic              w_status;
    logic signed [7:0] w_vx, w_vy;
    logic              w_vel_ok;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_pitch <= MAX_RESET;
            r_cfg.max_yaw   <= MAX_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MAX_PITCH: r_cfg.max_pitch <= i_cfg_wdata;
                REG_MAX_YAW:   r_cfg.max_yaw   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_in_valid = s_axis_tvalid;

    qpv_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_in_valid),
        .o_ready        (s_axis_tready),
        .i_quat_x       (s_axis_tdata[15:0]),
        .i_quat_y       (s_axis_tdata[31:16]),
        .i_quat_z       (s_axis_tdata[47:32]),
        .i_quat_w       (s_axis_tdata[63:48]),
        .i_toward_elbow (s_axis_tuser[0]),
        .i_pointer_mode (s_axis_tuser[1]),
        .o_push         (w_push),
        .o_work         (w_work),
        .i_full         (w_full)
    );

    qpv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_work),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    qpv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_cfg        (r_cfg),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_status     (w_status),
        .o_velocity_x (w_vx),
        .o_velocity_y (w_vy)
    );

    assign m_axis_tdata = {w_vy, w_vx};
    assign m_axis_tuser = w_status;

    // Both velocities within full scale.
    assign w_vel_ok = (w_vx >= -8'sd100) && (w_vx <= 8'sd100) &&
                      (w_vy >= -8'sd100) && (w_vy <= 8'sd100);

    // End of chain carries no velocity.
    `QPV_ASSERT_IMP(a_eoc_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "eoc velocity")
    // Velocities stay within full scale.
    `QPV_ASSERT_IMP(a_vel_range, m_axis_tvalid, w_vel_ok, "velocity beyond full scale")
    // The front never pushes into a full queue.
    `QPV_ASSERT_IMP(a_no_overflow, w_push, !w_full, "queue overflow")
    // A pitch maximum write lands in the next cycle.
    `QPV_ASSERT_NXT(a_cfg_pitch, i_cfg_we && (i_cfg_index == REG_MAX_PITCH), r_cfg.max_pitch == $past(i_cfg_wdata), "pitch maximum not written")

endmodule

`default_nettype wire

[dv/quaternion_to_pointer_velocity_top_tb.sv]
// ----------------------------------------------------------------------------
// quaternion_to_pointer_velocity_top_tb
// Drives quaternion words with random gaps and result back-pressure, predicts
// pointer velocity with an integer CORDIC model and checks every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_to_pointer_velocity_top_tb;
    import qpv_pkg::*;

    typedef struct {
        logic [0:0]        status;
        logic signed [7:0] vel_x;
        logic signed [7:0] vel_y;
    } t_velocity;

    // Holds the pointer state and the expected velocity words.
    class velocity_scoreboard;
        t_velocity pending[$];
        int        errors;
        int        max_pitch;
        int        max_yaw;
        bit        was_mouse;
        int        base_pitch;
        int        base_yaw;

        function new();
            errors = 0;
            max_pitch = 8192;
            max_yaw = 8192;
            was_mouse = 0;
            base_pitch = 0;
            base_yaw = 0;
        endfunction

        // Integer CORDIC arctangent as a signed 16-bit binary angle.
        function automatic int angle16(longint y, longint x);
            longint acc;
            longint t;
            longint xs;
            longint ys;
            int     u;
            acc = 0;
            if (x == 0) begin
                if (y == 0) return 0;
                return (y > 0) ? 16384 : -16384;
            end
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    acc = 64'sd4194304;
                end else begin
                    x = -y;
                    y = t;
                    acc = -64'sd4194304;
                end
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    acc += longint'(atan_entry(5'(i)));
                end else begin
                    x = x - ys;
                    y = y + xs;
                    acc -= longint'(atan_entry(5'(i)));
                end
            end
            u = int'(((acc + 128) >>> 8) & 64'hFFFF);
            return (u >= 32768) ? u - 65536 : u;
        endfunction

        function automatic longint root64(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function automatic int wrap_delta(int cur, int base);
            int d;
            if (cur == -32768 || base == -32768) return 0;
            d = cur - base;
            if (d > 32768) d -= 65536;
            else if (d < -32768) d += 65536;
            return d;
        endfunction

        function automatic int scale(int delta, int maxv);
            longint v;
            if (maxv == 0) maxv = 1;
            v = (longint'(delta) * 100) / maxv;
            if (v > 100) v = 100;
            if (v < -100) v = -100;
            return int'(v);
        endfunction

        // Notes one accepted quaternion word and queues its velocity.
        function void note_input(logic [63:0] q, logic [1:0] flags);
            longint    qx, qy, qz, qw, s, num, den;
            longint    c;
            int        pitch, yaw, u;
            bit        mouse;
            t_velocity e;
            qx = longint'($signed(q[15:0]));
            qy = longint'($signed(q[31:16]));
            qz = longint'($signed(q[47:32]));
            qw = longint'($signed(q[63:48]));
            mouse = flags[1];
            s = 2 * (qw * qy - qz * qx);
            if (s > (64'sd1 << 28)) s = 64'sd1 << 28;
            if (s < -(64'sd1 << 28)) s = -(64'sd1 << 28);
            c = root64(longint'(64'd1 << 56) - s * s);
            pitch = angle16(s, c);
            if (!flags[0]) pitch = -pitch;
            num = 2 * (qw * qz + qx * qy);
            den = (64'sd1 << 28) - 2 * (qy * qy + qz * qz);
            u = (-angle16(num, den)) & 16'hFFFF;
            yaw = (u >= 32768) ? u - 65536 : u;
            if (!was_mouse && mouse) begin
                base_pitch = pitch;
                base_yaw = yaw;
            end
            e.status = (!mouse && !was_mouse) ? 1'b1 : 1'b0;
            e.vel_x = '0;
            e.vel_y = '0;
            if (mouse) begin
                e.vel_y = 8'(scale(wrap_delta(pitch, base_pitch), max_pitch));
                e.vel_x = 8'(scale(wrap_delta(yaw, base_yaw), max_yaw));
            end
            was_mouse = mouse;
            pending.push_back(e);
        endfunction

        // Checks one result word against the oldest expectation.
        function void check_result(logic [15:0] d, logic [0:0] st);
            t_velocity e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, actual %h/%h", $time, st, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (d[7:0] !== e.vel_x) begin
                $display("%0t: velocity_x expected %0d actual %0d", $time, e.vel_x,
                         $signed(d[7:0]));
                errors++;
            end
            if (d[15:8] !== e.vel_y) begin
                $display("%0t: velocity_y expected %0d actual %0d", $time, e.vel_y,
                         $signed(d[15:8]));
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_we = 0;
    logic [0:0]  i_cfg_index = '0;
    logic [14:0] i_cfg_wdata = '0;

    velocity_scoreboard board = new();
    bit stim_done = 0;

    quaternion_to_pointer_velocity_top dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // Result side: a random wait, with ready low, before each word.
    initial begin
        int gap;
        forever begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Sends one word; valid stays high into a following word with no gap.
    task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic signed [15:0] w,
                             logic elbow, logic mouse, int gap);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= {w, z, y, x};
        s_axis_tuser <= {mouse, elbow};
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input({w, z, y, x}, {mouse, elbow});
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [14:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == REG_MAX_PITCH) board.max_pitch = val;
        else board.max_yaw = val;
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    initial begin
        logic signed [15:0] ax, ay, az, aw;
        logic               el;
        int                 n;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, zero vector, vertical, mode changes.
        send_word(0, 0, 0, 16384, 0, 0, 0);
        send_word(0, 0, 0, 16384, 1, 1, 0);
        send_word(0, 16384, 0, 16384, 1, 1, 0);
        send_word(0, -16384, 0, 16384, 0, 1, 0);
        send_word(0, 0, 16384, 0, 1, 1, 0);
        send_word(0, 0, 0, 0, 1, 1, 0);
        send_word(16384, 0, 0, 0, 0, 1, 1);
        send_word(-32768, 32767, -32768, 32767, 1, 1, 0);
        send_word(0, 0, 0, 16384, 1, 0, 0);
        send_word(0, 0, 0, 16384, 1, 0, 0);
        send_word(0, 0, 16384, 0, 1, 1, 0);
        send_word(0, 0, 11585, 11585, 1, 1, 0);
        send_word(0, 0, -11585, 11585, 1, 1, 0);
        send_word(-16384, 16384, -16384, 16384, 0, 1, 0);
        send_word(0, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // Random phases under several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(REG_MAX_PITCH, 15'd1); write_reg(REG_MAX_YAW, 15'd32767); end
                1: begin write_reg(REG_MAX_PITCH, 15'd32767); write_reg(REG_MAX_YAW, 15'd1); end
                2: begin write_reg(REG_MAX_PITCH, 15'd0); write_reg(REG_MAX_YAW, 15'd0); end
                default: begin
                    write_reg(REG_MAX_PITCH, 15'($urandom_range(1, 32767)));
                    write_reg(REG_MAX_YAW, 15'($urandom_range(1, 32767)));
                end
            endcase
            n = 0;
            while (n < 165) begin
                // Mostly mouse-mode runs, leaving and re-entering now and then.
                el = $urandom_range(0, 1);
                for (int k = $urandom_range(1, 20); k > 0; k--) begin
                    ax = rand_comp(); ay = rand_comp(); az = rand_comp(); aw = rand_comp();
                    send_word(ax, ay, az, aw, el, ($urandom_range(0, 9) != 0),
                              $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5));
                    n++;
                end
                send_word(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                          $urandom_range(0, 1), 0, $urandom_range(0, 5));
                n++;
            end
            wait_idle();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/qpv_pkg.sv
design/qpv_front.sv
design/qpv_queue.sv
design/qpv_back.sv
design/quaternion_to_pointer_velocity_top.sv
dv/quaternion_to_pointer_velocity_top_tb.sv
